/* design/json_structural_indexer_unit_defines.svh */
// ----------------------------------------------------------------------------
// JSON structural indexer assertion macros
// Concurrent assertion helpers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef JSON_STRUCTURAL_INDEXER_UNIT_DEFINES_SVH
`define JSON_STRUCTURAL_INDEXER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define JSI_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("jsi assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define JSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsi assertion failed");

`else

`define JSI_ASSERT(label, clk, rst_n, prop)

`define JSI_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* design/jsi_pkg.sv */
// ----------------------------------------------------------------------------
// JSON structural indexer package
// Character codes, lane geometry, shared types and the byte classifier.
// ----------------------------------------------------------------------------
package jsi_pkg;

    localparam int unsigned LANES  = 8;
    localparam int unsigned WORD_W = 8 * LANES;

    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;

    typedef struct packed {
        logic is_bslash;
        logic is_quote;
        logic is_open;
        logic is_close;
        logic is_sep;
    } byte_class_t;

    typedef struct packed {
        logic bslash_odd;
        logic in_string;
    } scan_state_t;

    typedef struct packed {
        logic [LANES-1:0] structural;
        logic [LANES-1:0] open;
        logic [LANES-1:0] close;
    } mask_set_t;

    function automatic byte_class_t classify(input logic [7:0] ch);
        byte_class_t c;
        c = '0;
        unique case (ch) inside
            CH_BSLASH:              c.is_bslash = 1'b1;
            CH_QUOTE:               c.is_quote  = 1'b1;
            CH_LBRACE, CH_LBRACKET: c.is_open   = 1'b1;
            CH_RBRACE, CH_RBRACKET: c.is_close  = 1'b1;
            CH_COLON, CH_COMMA:     c.is_sep    = 1'b1;
            default:                c = '0;
        endcase
        return c;
    endfunction

endpackage

/* design/jsi_text_if.sv */
// ----------------------------------------------------------------------------
// JSON structural indexer text channel
// Valid/ready channel carrying one 64-bit word of JSON text per request.
// ----------------------------------------------------------------------------
interface jsi_text_if;

    logic                         valid;
    logic                         ready;
    logic [jsi_pkg::WORD_W-1:0]   data_word;

    modport source (output valid, output data_word, input ready);
    modport sink   (input valid, input data_word, output ready);

endinterface

/* design/jsi_mask_if.sv */
// ----------------------------------------------------------------------------
// JSON structural indexer mask channel
// Valid/ready channel carrying the three per-byte masks of one word.
// ----------------------------------------------------------------------------
interface jsi_mask_if;

    logic                        valid;
    logic                        ready;
    logic [jsi_pkg::LANES-1:0]   structural_mask;
    logic [jsi_pkg::LANES-1:0]   open_mask;
    logic [jsi_pkg::LANES-1:0]   close_mask;

    modport source (output valid, output structural_mask, output open_mask,
                    output close_mask, input ready);
    modport sink   (input valid, input structural_mask, input open_mask,
                    input close_mask, output ready);

endinterface

/* design/jsi_scan.sv */
// ----------------------------------------------------------------------------
// JSON structural indexer lane scan
// Ripples escape parity and string state across the byte lanes of one word
// and builds the structural, opener and closer masks.
// ----------------------------------------------------------------------------
module jsi_scan #(
    parameter int unsigned BYTES_PER_ITEM = 8
) (
    input  logic [jsi_pkg::WORD_W-1:0] data_word,
    input  jsi_pkg::scan_state_t       state,
    output jsi_pkg::scan_state_t       state_next,
    output jsi_pkg::mask_set_t         masks
);

    always_comb
    begin
        jsi_pkg::scan_state_t st;
        jsi_pkg::byte_class_t cls;
        logic                 escaped;
        st    = state;
        masks = '0;
        for (int lane = 0; lane < jsi_pkg::LANES; lane++)
        begin
            cls     = jsi_pkg::classify(data_word[lane*8 +: 8]);
            escaped = st.bslash_odd;
            if (lane < BYTES_PER_ITEM)
            begin
                if (cls.is_bslash)
                begin
                    st.bslash_odd = ~st.bslash_odd;
                end
                else
                begin
                    st.bslash_odd = 1'b0;
                    if (cls.is_quote)
                    begin
                        if (!escaped)
                        begin
                            st.in_string = ~st.in_string;
                        end
                    end
                    else if (!st.in_string)
                    begin
                        masks.open[lane]       = cls.is_open;
                        masks.close[lane]      = cls.is_close;
                        masks.structural[lane] = cls.is_open | cls.is_close | cls.is_sep;
                    end
                end
            end
        end
        state_next = st;
    end

endmodule

/* design/json_structural_indexer_unit.sv */
// ----------------------------------------------------------------------------
// JSON structural indexer
// Flags unquoted structural characters of a JSON byte stream, 8 bytes a word.
// ----------------------------------------------------------------------------
// text: one request per word of JSON text, byte zero in data_word[7:0].
// marks: one request per word with three masks, bit i for byte i:
//   structural_mask (colon, comma, brace, bracket), open_mask ('{' '['),
//   close_mask ('}' ']'). Bytes inside a string literal set no bit.
// Path: an accepted text word is held in the input register, passes the lane
// scan and is registered in the result register, which drives marks.
// Throughput: one word per cycle unless marks stalls; escape parity and string
// state ripple through the scanned lanes and are held in two flops across words.
// The text side keeps accepting while a result waits in the result
// register; with marks stalled and both registers full, text.ready drops.
// Reset clears both valid flags, the backslash parity and the string state.
// BYTES_PER_ITEM (1..8) sets how many low lanes are scanned; higher lanes
// are ignored and their mask bits are zero.
// ----------------------------------------------------------------------------
`include "json_structural_indexer_unit_defines.svh"

module json_structural_indexer_unit #(
    parameter int unsigned BYTES_PER_ITEM = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    jsi_text_if.sink   text,
    jsi_mask_if.source marks
);

    localparam int unsigned      USED_LANES = (BYTES_PER_ITEM > jsi_pkg::LANES) ?
                                              jsi_pkg::LANES : BYTES_PER_ITEM;
    localparam logic [jsi_pkg::LANES-1:0] LANE_MASK =
        jsi_pkg::LANES'((9'd1 << USED_LANES) - 9'd1);

    logic [jsi_pkg::WORD_W-1:0] text_reg;
    logic                       text_vld_reg;
    jsi_pkg::scan_state_t       state_reg;
    jsi_pkg::scan_state_t       state_next;
    jsi_pkg::mask_set_t         mask_reg;
    jsi_pkg::mask_set_t         mask_next;
    logic                       mask_vld_reg;
    logic                       advance;
    logic                       text_take;

    assign advance   = text_vld_reg && (!mask_vld_reg || marks.ready);
    assign text.ready = !text_vld_reg || advance;
    assign text_take = text.valid && text.ready;

    jsi_scan #(
        .BYTES_PER_ITEM (USED_LANES)
    ) u_scan (
        .data_word  (text_reg),
        .state      (state_reg),
        .state_next (state_next),
        .masks      (mask_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_vld_reg <= 1'b0;
            mask_vld_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            if (text.ready)
            begin
                text_vld_reg <= text.valid;
            end
            if (advance)
            begin
                state_reg    <= state_next;
                mask_vld_reg <= 1'b1;
            end
            else if (marks.ready)
            begin
                mask_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_take)
        begin
            text_reg <= text.data_word;
        end
        if (advance)
        begin
            mask_reg <= mask_next;
        end
    end

    assign marks.valid           = mask_vld_reg;
    assign marks.structural_mask = mask_reg.structural;
    assign marks.open_mask       = mask_reg.open;
    assign marks.close_mask      = mask_reg.close;

    // openers and closers are disjoint and both are structural
    `JSI_ASSERT(a_mask_consistent, clk, rst_n,
        !mask_vld_reg || (((mask_reg.open & mask_reg.close) == '0) &&
        (((mask_reg.open | mask_reg.close) & ~mask_reg.structural) == '0)))

    // lanes beyond the configured width never flag
    `JSI_ASSERT(a_unused_lanes_clear, clk, rst_n,
        !mask_vld_reg || ((mask_reg.structural & ~LANE_MASK) == '0))

    // scan state moves only with a word going into the result register
    `JSI_ASSERT_NEXT(a_state_hold, clk, rst_n, !advance, $stable(state_reg))

    // a buffered word moves forward when the result register is free
    `JSI_ASSERT_NEXT(a_fill_result, clk, rst_n, text_vld_reg && !mask_vld_reg,
        mask_vld_reg)

endmodule
